// File: design/bcut_pkg.sv
// bcut_pkg: shared types and constants for the byte/code point translator
// depends on nothing; used by bcut_table, bcut_ctrl and the top level
package bcut_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int BYTE_SPAN   = 256;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int BYTE_W      = 8;
  localparam int CODE_W      = 21;
  localparam int PREFIX_W    = 9;
  localparam int OP_W        = 2;

  localparam logic [PREFIX_W-1:0] PREFIX_RESET = PREFIX_W'(128);

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_FWD  = 2'd1;
  localparam logic [OP_W-1:0] OP_REV  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] byte_code;
    logic [CODE_W-1:0] code_point;
  } bcut_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] result_code;
    logic              unmapped;
  } bcut_result_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [IDX_W-1:0]  addr;
    logic [CODE_W-1:0] wr_data;
  } bcut_mem_req_t;

  typedef struct packed {
    logic [CODE_W-1:0] rd_data;
    logic              rd_valid;
  } bcut_mem_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FWD,
    ST_SCAN
  } bcut_state_t;

endpackage

// File: design/bcut_table.sv
// bcut_table: code point store with one shared read/write port and per-entry loaded flags
// depends on bcut_pkg
module bcut_table (
  input  logic                   clk,
  input  logic                   rst,
  input  bcut_pkg::bcut_mem_req_t req,
  output bcut_pkg::bcut_mem_rsp_t rsp
);
  import bcut_pkg::*;

  logic [CODE_W-1:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] loaded;
  logic [CODE_W-1:0]      rd_data;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.addr];
    end
  end

  // flags clear at reset, so stale memory contents never count as loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (req.wr_en) begin
      loaded[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid <= loaded[req.addr];
    end
  end

  assign rsp.rd_data  = rd_data;
  assign rsp.rd_valid = rd_valid;

endmodule

// File: design/bcut_ctrl.sv
// bcut_ctrl: command sequencer for load, forward lookup and reverse table scan
// depends on bcut_pkg; drives bcut_table through its request struct
module bcut_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  bcut_pkg::bcut_item_t    item,
  input  logic [bcut_pkg::PREFIX_W-1:0] eff_prefix,
  output logic                    busy,
  output logic                    done,
  output bcut_pkg::bcut_result_t  result,
  output bcut_pkg::bcut_mem_req_t mem_req,
  input  bcut_pkg::bcut_mem_rsp_t mem_rsp
);
  import bcut_pkg::*;

  localparam logic [IDX_W-1:0]    LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [PREFIX_W-1:0] DEPTH_PFX = PREFIX_W'(TABLE_DEPTH);

  bcut_state_t       state, state_next;
  logic [IDX_W-1:0]  scan_idx, scan_idx_next;
  logic [CODE_W-1:0] cp_reg;
  logic              done_next;
  bcut_result_t      result_next;
  logic              accept;
  logic              byte_in_table;
  logic              byte_in_prefix;
  logic              cp_in_prefix;

  assign accept         = start && !busy;
  assign busy           = (state != ST_IDLE);
  assign byte_in_table  = ({1'b0, item.byte_code} < DEPTH_PFX);
  assign byte_in_prefix = ({1'b0, item.byte_code} < eff_prefix);
  assign cp_in_prefix   = (item.code_point < CODE_W'(eff_prefix));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx <= scan_idx_next;
    result   <= result_next;
    if (accept) begin
      cp_reg <= item.code_point;
    end
  end

  always_comb begin
    state_next          = state;
    scan_idx_next       = scan_idx;
    done_next           = 1'b0;
    result_next         = '0;
    mem_req             = '0;
    mem_req.wr_data     = item.code_point;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.op)
            OP_LOAD: begin
              done_next     = 1'b1;
              mem_req.wr_en = byte_in_table;
              mem_req.addr  = item.byte_code[IDX_W-1:0];
            end
            OP_FWD: begin
              if (byte_in_prefix) begin
                done_next               = 1'b1;
                result_next.result_code = {{(CODE_W-BYTE_W){1'b0}}, item.byte_code};
              end else if (!byte_in_table) begin
                done_next            = 1'b1;
                result_next.unmapped = 1'b1;
              end else begin
                mem_req.rd_en = 1'b1;
                mem_req.addr  = item.byte_code[IDX_W-1:0];
                state_next    = ST_FWD;
              end
            end
            OP_REV: begin
              if (cp_in_prefix) begin
                done_next               = 1'b1;
                result_next.result_code = item.code_point;
              end else if (eff_prefix >= DEPTH_PFX) begin
                done_next            = 1'b1;
                result_next.unmapped = 1'b1;
              end else begin
                // first read at the prefix, then one entry per cycle
                mem_req.rd_en = 1'b1;
                mem_req.addr  = eff_prefix[IDX_W-1:0];
                scan_idx_next = eff_prefix[IDX_W-1:0];
                state_next    = ST_SCAN;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      ST_FWD: begin
        done_next  = 1'b1;
        state_next = ST_IDLE;
        if (mem_rsp.rd_valid) begin
          result_next.result_code = mem_rsp.rd_data;
        end else begin
          result_next.unmapped = 1'b1;
        end
      end
      ST_SCAN: begin
        // scan_idx names the entry whose read data is on mem_rsp now
        if (mem_rsp.rd_valid && (mem_rsp.rd_data == cp_reg)) begin
          done_next               = 1'b1;
          result_next.result_code = {{(CODE_W-IDX_W){1'b0}}, scan_idx};
          state_next              = ST_IDLE;
        end else if (scan_idx == LAST_IDX) begin
          done_next            = 1'b1;
          result_next.unmapped = 1'b1;
          state_next           = ST_IDLE;
        end else begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = scan_idx + IDX_W'(1);
          scan_idx_next = scan_idx + IDX_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_quiet_ops: assert property (@(posedge clk) disable iff (rst)
    (accept && item.op != OP_FWD && item.op != OP_REV)
      |=> (done && !result.unmapped && result.result_code == '0))
    else $error("load or unused op did not give a zero beat");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.unmapped) |-> (result.result_code == '0))
    else $error("miss beat carries a nonzero code");

  a_fwd_one: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FWD) |=> (done && state == ST_IDLE))
    else $error("forward lookup did not finish after one read");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> (($past(start) && !$past(busy)) || $past(state) != ST_IDLE))
    else $error("result beat without an accepted item");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    busy |-> !mem_req.wr_en)
    else $error("table written during a lookup");

endmodule

// File: design/byte_codepage_unicode_translator_core.sv
// byte_codepage_unicode_translator_core: top level, holds the prefix register
// depends on bcut_pkg, bcut_table, bcut_ctrl
//
//  channel  | ports                  | flow
//  ---------+------------------------+-------------------------------------
//  command  | start, busy, item      | accepted when start && !busy
//  result   | done, result           | one beat per command, done for 1 cycle
//  config   | cfg_we, cfg_data       | identity prefix, written when cfg_we
//
// load, unused op, identity hit, out-of-table byte: beat in the next cycle
// forward table lookup: one table read, then the beat from ST_FWD
// reverse scan: from the prefix up to the last entry, one entry per cycle
//   through the table's single read port
// reset: prefix 128, all entries unloaded at once; no clearing pass
// busy is high only during a table read or scan; results cannot be held off
module byte_codepage_unicode_translator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bcut_pkg::bcut_item_t          item,
  output logic                          done,
  output bcut_pkg::bcut_result_t        result,
  input  logic                          cfg_we,
  input  logic [bcut_pkg::PREFIX_W-1:0] cfg_data
);
  import bcut_pkg::*;

  localparam logic [PREFIX_W-1:0] SPAN_PFX = PREFIX_W'(BYTE_SPAN);

  logic [PREFIX_W-1:0] prefix;
  logic [PREFIX_W-1:0] eff_prefix;
  bcut_mem_req_t       mem_req;
  bcut_mem_rsp_t       mem_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= PREFIX_RESET;
    end else if (cfg_we) begin
      prefix <= cfg_data;
    end
  end

  // prefix values past the byte range behave as the full range
  assign eff_prefix = (prefix > SPAN_PFX) ? SPAN_PFX : prefix;

  bcut_table u_table (
    .clk (clk),
    .rst (rst),
    .req (mem_req),
    .rsp (mem_rsp)
  );

  bcut_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .item       (item),
    .eff_prefix (eff_prefix),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .mem_req    (mem_req),
    .mem_rsp    (mem_rsp)
  );

endmodule

// File: tb/sv/byte_codepage_unicode_translator_core_test.sv
// self-checking bench for byte_codepage_unicode_translator_core: loads, forward and
// reverse lookups under several identity prefixes, checked against a table model
// depends on bcut_pkg and the translator core rtl
module byte_codepage_unicode_translator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bcut_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // table model plus the queue of beats still owed by the core
  class translation_scoreboard;
    int unsigned       prefix;
    logic [CODE_W-1:0] code_table [BYTE_SPAN];
    bit                loaded [BYTE_SPAN];
    bcut_result_t      owed [$];
    int errors, n_load, n_fwd, n_rev, n_other, n_unmapped;

    function new();
      prefix = 128;
      foreach (loaded[i]) begin
        loaded[i] = 1'b0;
        code_table[i] = '0;
      end
    endfunction

    function void set_prefix(logic [PREFIX_W-1:0] v);
      prefix = (v > BYTE_SPAN) ? BYTE_SPAN : v;
    endfunction

    function void note_item(bcut_item_t it);
      bcut_result_t exp;
      exp = '0;
      case (it.op)
        OP_LOAD: begin
          n_load++;
          if (it.byte_code < TABLE_DEPTH) begin
            code_table[it.byte_code] = it.code_point;
            loaded[it.byte_code] = 1'b1;
          end
        end
        OP_FWD: begin
          n_fwd++;
          if (it.byte_code < prefix) exp.result_code = CODE_W'(it.byte_code);
          else if (it.byte_code < TABLE_DEPTH && loaded[it.byte_code])
            exp.result_code = code_table[it.byte_code];
          else exp.unmapped = 1'b1;
        end
        OP_REV: begin
          n_rev++;
          if (it.code_point < prefix) begin
            exp.result_code = it.code_point;
          end else begin
            exp.unmapped = 1'b1;
            for (int i = prefix; i < TABLE_DEPTH; i++) begin
              if (loaded[i] && code_table[i] == it.code_point) begin
                exp.result_code = CODE_W'(i);
                exp.unmapped = 1'b0;
                break;
              end
            end
          end
        end
        default: n_other++;
      endcase
      owed.push_back(exp);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(bcut_result_t got);
      bcut_result_t exp;
      if (got.unmapped === 1'b1) n_unmapped++;
      if (owed.size() == 0) begin
        report($sformatf("result beat code=%0h unmapped=%b with nothing outstanding",
                         got.result_code, got.unmapped));
      end else begin
        exp = owed.pop_front();
        if (got.result_code !== exp.result_code)
          report($sformatf("result_code %0h, wanted %0h", got.result_code, exp.result_code));
        if (got.unmapped !== exp.unmapped)
          report($sformatf("unmapped %b, wanted %b", got.unmapped, exp.unmapped));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  bcut_item_t            item = '0;
  logic                  done;
  bcut_result_t          result;
  logic                  cfg_we = 1'b0;
  logic [PREFIX_W-1:0]   cfg_data = '0;

  translation_scoreboard sb = new();
  int n_cfg = 0;

  always #4 clk = ~clk;

  byte_codepage_unicode_translator_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(result);
  end

  function automatic bcut_item_t mk(logic [OP_W-1:0] op, int b, int cp);
    bcut_item_t it;
    it.op = op;
    it.byte_code = BYTE_W'(b);
    it.code_point = CODE_W'(cp);
    return it;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    logic [CODE_W-1:0] edges [4] = '{21'h0, 21'h10FFFF, 21'h110000, 21'h1FFFFF};
    case ($urandom_range(0, 3))
      0: return CODE_W'($urandom_range(0, 21'h1FFFFF));
      1: return CODE_W'(12'h100 + $urandom_range(0, 7));  // small pool, many duplicates
      2: return edges[$urandom_range(0, 3)];
      default: return CODE_W'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic bcut_item_t next_item();
    bcut_item_t it;
    int pick, slot;
    pick = $urandom_range(0, 99);
    it.byte_code = BYTE_W'($urandom);
    it.code_point = pick_code();
    if (pick < 30) begin
      it.op = OP_LOAD;
    end else if (pick < 60) begin
      it.op = OP_FWD;
    end else if (pick < 95) begin
      it.op = OP_REV;
      slot = $urandom_range(0, BYTE_SPAN - 1);
      case ($urandom_range(0, 3))
        0, 1: if (sb.loaded[slot]) it.code_point = sb.code_table[slot];
        2: if (sb.prefix > 0) it.code_point = CODE_W'($urandom_range(0, sb.prefix - 1));
        default: ;
      endcase
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the accepting beat
  task automatic send(input bcut_item_t it, input bit idle_on);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      item <= $bits(bcut_item_t)'($urandom);
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic switch_prefix(input logic [PREFIX_W-1:0] v);
    start <= 1'b0;
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_prefix(v);
    n_cfg++;
    @(negedge clk);
  endtask

  task automatic random_run(input logic [PREFIX_W-1:0] v, input int count, input bit idle_on);
    switch_prefix(v);
    repeat (count) send(next_item(), idle_on);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset prefix of 128, identity only
    send(mk(OP_FWD, 127, 0), 1'b0);
    send(mk(OP_REV, 0, 127), 1'b0);

    // whole byte range is identity: no table reads at all
    switch_prefix(9'd256);
    send(mk(OP_LOAD, 0, 21'h1FFFFF), 1'b1);
    send(mk(OP_LOAD, 255, 0), 1'b1);
    send(mk(OP_LOAD, 128, 21'h10FFFF), 1'b1);
    send(mk(OP_FWD, 0, 21'h1FFFFF), 1'b1);
    send(mk(OP_FWD, 255, 0), 1'b1);
    send(mk(OP_REV, 0, 0), 1'b1);
    send(mk(OP_REV, 0, 255), 1'b1);
    send(mk(OP_REV, 0, 256), 1'b1);
    send(mk(OP_REV, 255, 21'h1FFFFF), 1'b1);
    send(mk(OP_UNUSED, 255, 21'h1FFFFF), 1'b1);
    send(mk(OP_UNUSED, 0, 0), 1'b1);

    // register above 256 saturates
    switch_prefix(9'h1FF);
    send(mk(OP_REV, 0, 256), 1'b0);
    send(mk(OP_REV, 0, 21'h10FFFF), 1'b0);
    send(mk(OP_FWD, 200, 0), 1'b0);
    send(mk(OP_UNUSED, 8'hA5, 21'h0AAAAA), 1'b0);

    random_run(9'd128, 200, 1'b1);
    random_run(9'd0, 250, 1'b1);
    random_run(9'd300, 150, 1'b1);
    random_run(9'd1, 200, 1'b1);
    random_run(9'd255, 200, 1'b1);
    random_run(PREFIX_W'($urandom_range(2, 254)), 200, 1'b1);
    random_run(PREFIX_W'($urandom_range(0, 511)), 200, 1'b1);
    random_run(9'd0, 280, 1'b0);

    start <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (sb.owed.size() != 0)
      sb.report($sformatf("%0d expected beats never arrived", sb.owed.size()));

    $display("%0d loads, %0d forward, %0d reverse, %0d unused-op commands; %0d unmapped beats",
             sb.n_load, sb.n_fwd, sb.n_rev, sb.n_other, sb.n_unmapped);
    $display("%0d prefix settings from 0 to 511, with and without sender gaps", n_cfg);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
design/bcut_pkg.sv
design/bcut_table.sv
design/bcut_ctrl.sv
design/byte_codepage_unicode_translator_core.sv
tb/sv/byte_codepage_unicode_translator_core_test.sv
